// ----- rtl/sfa_pkg.sv -----
package sfa_pkg;

  // Command codes carried on the command field.
  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_SQR = 3'd3,
    CMD_INV = 3'd4
  } cmd_e;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_IDLE     = 5'd0,
    OP_LOAD     = 5'd1,
    OP_ADD      = 5'd2,
    OP_SUB      = 5'd3,
    OP_ZERO     = 5'd4,
    OP_FIXC     = 5'd5,
    OP_FIXP     = 5'd6,
    OP_CSUB     = 5'd7,
    OP_MSEL     = 5'd8,
    OP_PROD     = 5'd9,
    OP_FLUSH    = 5'd10,
    OP_FOLD     = 5'd11,
    OP_F2MUL    = 5'd12,
    OP_F2ADD    = 5'd13,
    OP_ST_ACC   = 5'd14,
    OP_ST_BASE  = 5'd15,
    OP_INV_RES  = 5'd16,
    OP_OUT      = 5'd17
  } op_e;

  // Operand pair loaded into the multiplier registers.
  typedef enum logic [1:0] {
    MSEL_A_B       = 2'd0,
    MSEL_A_A       = 2'd1,
    MSEL_ACC_BASE  = 2'd2,
    MSEL_BASE_BASE = 2'd3
  } msel_e;

  // Command bundle from the controller to the datapath.
  typedef struct packed {
    op_e         op;
    msel_e       msel;
    logic [2:0]  mul_i;
    logic [2:0]  mul_j;
    logic        col_last;
    logic        fold_low;
    logic        fold_sh;
  } dp_cmd_t;

  localparam logic [255:0] PRIME =
    256'hFFFFFFFFFFFFFFFF_FFFFFFFFFFFFFFFF_FFFFFFFFFFFFFFFF_FFFFFFFEFFFFFC2F;
  localparam logic [255:0] INV_EXP =
    256'hFFFFFFFFFFFFFFFF_FFFFFFFFFFFFFFFF_FFFFFFFFFFFFFFFF_FFFFFFFEFFFFFC2D;
  // 2^256 mod p.
  localparam logic [255:0] FOLD_C = 256'h1000003D1;
  // Low part of the fold constant, 2^256 mod p minus 2^32.
  localparam logic [31:0]  FOLD_LO = 32'd977;
  localparam logic [9:0]   FOLD_LO_N = 10'd977;

endpackage

// ----- rtl/secp256k1_field_alu_top.sv -----
// Channel | Signals                                   | Beat
// input   | in_valid_i, in_stall_o                    | command_i, operand_a/b limbs
// output  | out_valid_o, out_stall_i                  | result_limb_0..3_o
//
// One item is worked on at a time. Add runs ARITH, FIXC, CSUB, OUT; sub runs
// ARITH, FIXP, OUT; unused codes run ARITH (zero) and OUT. Mul and square run on
// the shared 32x32 multiplier, which makes 64 limb products and 9 fold steps.
// Inverse runs 505 multiplications.
// Reset clears the controller and the multiplier-stage valid flag only; no clearing pass.
// A stalled result holds in the output register; the next item may be accepted, but its result waits in S_OUT.
module secp256k1_field_alu_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [63:0] operand_a_limb_0_i,
  input  logic [63:0] operand_a_limb_1_i,
  input  logic [63:0] operand_a_limb_2_i,
  input  logic [63:0] operand_a_limb_3_i,
  input  logic [63:0] operand_b_limb_0_i,
  input  logic [63:0] operand_b_limb_1_i,
  input  logic [63:0] operand_b_limb_2_i,
  input  logic [63:0] operand_b_limb_3_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_limb_0_o,
  output logic [63:0] result_limb_1_o,
  output logic [63:0] result_limb_2_o,
  output logic [63:0] result_limb_3_o
);
  import sfa_pkg::*;

  dp_cmd_t ctl;

  // Sequencer.
  sfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .ctl_o       (ctl)
  );

  // Arithmetic datapath.
  sfa_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctl_i              (ctl),
    .operand_a_limb_0_i (operand_a_limb_0_i),
    .operand_a_limb_1_i (operand_a_limb_1_i),
    .operand_a_limb_2_i (operand_a_limb_2_i),
    .operand_a_limb_3_i (operand_a_limb_3_i),
    .operand_b_limb_0_i (operand_b_limb_0_i),
    .operand_b_limb_1_i (operand_b_limb_1_i),
    .operand_b_limb_2_i (operand_b_limb_2_i),
    .operand_b_limb_3_i (operand_b_limb_3_i),
    .result_limb_0_o    (result_limb_0_o),
    .result_limb_1_o    (result_limb_1_o),
    .result_limb_2_o    (result_limb_2_o),
    .result_limb_3_o    (result_limb_3_o)
  );

endmodule

// ----- rtl/sfa_dp.sv -----
module sfa_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfa_pkg::dp_cmd_t  ctl_i,
  input  logic [63:0]       operand_a_limb_0_i,
  input  logic [63:0]       operand_a_limb_1_i,
  input  logic [63:0]       operand_a_limb_2_i,
  input  logic [63:0]       operand_a_limb_3_i,
  input  logic [63:0]       operand_b_limb_0_i,
  input  logic [63:0]       operand_b_limb_1_i,
  input  logic [63:0]       operand_b_limb_2_i,
  input  logic [63:0]       operand_b_limb_3_i,
  output logic [63:0]       result_limb_0_o,
  output logic [63:0]       result_limb_1_o,
  output logic [63:0]       result_limb_2_o,
  output logic [63:0]       result_limb_3_o
);
  import sfa_pkg::*;

  logic [255:0] a_q, b_q, x_q, y_q, acc_inv_q, base_inv_q, s_q, res_q;
  logic         c_q;
  logic [31:0]  t_q [16];
  logic [287:0] f_q;
  logic [69:0]  acc_q;
  logic [63:0]  p_q;
  logic         v1_q, last_q, fold1_q;
  logic [31:0]  lo_q, sh_q;
  logic [49:0]  m2_q;

  logic [31:0]  mul_a, mul_b;
  logic [63:0]  prod_d;
  logic [69:0]  sum_d;
  logic [39:0]  fh;
  logic [256:0] add_sum, sub_dif, csub_dif, f2_sum;
  logic [255:0] mx, my;

  // Shared 32x32 multiplier: limb products, or the fold by 977.
  always_comb begin
    if (ctl_i.op == OP_FOLD) begin
      mul_a = t_q[8];
      mul_b = FOLD_LO;
    end else begin
      mul_a = x_q[{ctl_i.mul_i, 5'b0} +: 32];
      mul_b = y_q[{ctl_i.mul_j, 5'b0} +: 32];
    end
  end
  assign prod_d = 64'(mul_a) * 64'(mul_b);

  // Column accumulator input and wide adders.
  assign sum_d    = acc_q + 70'(p_q) + 70'(lo_q) + 70'(sh_q);
  assign fh       = {acc_q[7:0], f_q[287:256]};
  assign add_sum  = {1'b0, a_q} + {1'b0, b_q};
  assign sub_dif  = {1'b0, a_q} - {1'b0, b_q};
  assign csub_dif = {1'b0, s_q} - {1'b0, PRIME};
  assign f2_sum   = {1'b0, f_q[255:0]} + {185'b0, fh, 32'b0} + 257'(m2_q);

  // Operand pair for the next multiplication.
  always_comb begin
    case (ctl_i.msel)
      MSEL_A_B: begin
        mx = a_q;
        my = b_q;
      end
      MSEL_A_A: begin
        mx = a_q;
        my = a_q;
      end
      MSEL_ACC_BASE: begin
        mx = acc_inv_q;
        my = base_inv_q;
      end
      default: begin
        mx = base_inv_q;
        my = base_inv_q;
      end
    endcase
  end

  // Valid flag of the multiplier stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= (ctl_i.op == OP_PROD) || (ctl_i.op == OP_FOLD);
    end
  end

  // Multiplier stage registers.
  always_ff @(posedge clk_i) begin
    p_q     <= prod_d;
    last_q  <= (ctl_i.op == OP_FOLD) || ctl_i.col_last;
    fold1_q <= (ctl_i.op == OP_FOLD);
    lo_q    <= ((ctl_i.op == OP_FOLD) && ctl_i.fold_low) ? t_q[0] : 32'd0;
    sh_q    <= ((ctl_i.op == OP_FOLD) && ctl_i.fold_sh) ? t_q[7] : 32'd0;
  end

  // Product limbs: columns enter at the top and move down; the fold reads them back.
  always_ff @(posedge clk_i) begin
    if (ctl_i.op == OP_FOLD) begin
      for (int k = 0; k < 15; k++) t_q[k] <= t_q[k+1];
      t_q[15] <= 32'd0;
    end else if (ctl_i.op == OP_FLUSH) begin
      for (int k = 0; k < 15; k++) t_q[k] <= t_q[k+1];
      t_q[15] <= acc_q[31:0];
    end else if (v1_q && last_q && !fold1_q) begin
      for (int k = 0; k < 15; k++) t_q[k] <= t_q[k+1];
      t_q[15] <= sum_d[31:0];
    end
  end

  // Column accumulator and first fold result.
  always_ff @(posedge clk_i) begin
    if ((ctl_i.op == OP_MSEL) || (ctl_i.op == OP_FLUSH)) begin
      acc_q <= 70'd0;
    end else if (v1_q) begin
      acc_q <= last_q ? (sum_d >> 32) : sum_d;
    end
    if (v1_q && last_q && fold1_q) begin
      f_q <= {sum_d[31:0], f_q[287:32]};
    end
  end

  // Operand, working and result registers.
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      OP_LOAD: begin
        a_q        <= {operand_a_limb_3_i, operand_a_limb_2_i,
                       operand_a_limb_1_i, operand_a_limb_0_i};
        b_q        <= {operand_b_limb_3_i, operand_b_limb_2_i,
                       operand_b_limb_1_i, operand_b_limb_0_i};
        acc_inv_q  <= 256'd1;
        base_inv_q <= {operand_a_limb_3_i, operand_a_limb_2_i,
                       operand_a_limb_1_i, operand_a_limb_0_i};
      end
      OP_ADD: begin
        {c_q, s_q} <= add_sum;
      end
      OP_SUB: begin
        {c_q, s_q} <= sub_dif;
      end
      OP_ZERO: begin
        s_q <= 256'd0;
      end
      OP_FIXC: begin
        if (c_q) s_q <= s_q + FOLD_C;
      end
      OP_FIXP: begin
        if (c_q) s_q <= s_q + PRIME;
      end
      OP_CSUB: begin
        if (!csub_dif[256]) s_q <= csub_dif[255:0];
      end
      OP_MSEL: begin
        x_q <= mx;
        y_q <= my;
      end
      OP_F2MUL: begin
        m2_q <= 50'(fh) * 50'(FOLD_LO_N);
      end
      OP_F2ADD: begin
        {c_q, s_q} <= f2_sum;
      end
      OP_ST_ACC: begin
        acc_inv_q <= s_q;
      end
      OP_ST_BASE: begin
        base_inv_q <= s_q;
      end
      OP_INV_RES: begin
        s_q <= acc_inv_q;
      end
      OP_OUT: begin
        res_q <= s_q;
      end
      default: begin
      end
    endcase
  end

  assign result_limb_0_o = res_q[63:0];
  assign result_limb_1_o = res_q[127:64];
  assign result_limb_2_o = res_q[191:128];
  assign result_limb_3_o = res_q[255:192];

endmodule

// ----- rtl/sfa_ctrl.sv -----
module sfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [2:0]        command_i,
  input  logic              out_stall_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output sfa_pkg::dp_cmd_t  ctl_o
);
  import sfa_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_ARITH = 16'h0002,
    S_FIXC  = 16'h0004,
    S_FIXP  = 16'h0008,
    S_CSUB  = 16'h0010,
    S_INV   = 16'h0020,
    S_MSEL  = 16'h0040,
    S_PROD  = 16'h0080,
    S_PWAIT = 16'h0100,
    S_FLUSH = 16'h0200,
    S_FOLD  = 16'h0400,
    S_FWAIT = 16'h0800,
    S_F2MUL = 16'h1000,
    S_F2ADD = 16'h2000,
    S_STORE = 16'h4000,
    S_OUT   = 16'h8000
  } state_e;

  state_e      state_q, state_d;
  logic [2:0]  cmd_q, cmd_d;
  logic [3:0]  k_q, k_d, k1;
  logic [2:0]  i_q, i_d, i_hi;
  logic [3:0]  step_q, step_d;
  logic [8:0]  n_q, n_d;
  logic        phase_q, phase_d;
  logic        out_valid_q, out_valid_d;

  // Column bounds of the product scan.
  assign i_hi = (k_q > 4'd7) ? 3'd7 : k_q[2:0];
  assign k1   = k_q + 4'd1;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    k_d         = k_q;
    i_d         = i_q;
    step_d      = step_q;
    n_d         = n_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && out_stall_i;
    ctl_o       = '0;
    ctl_o.op    = OP_IDLE;
    ctl_o.mul_i = i_q;
    ctl_o.mul_j = 3'(k_q - 4'(i_q));
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.op = OP_LOAD;
          cmd_d    = command_i;
          n_d      = 9'd0;
          phase_d  = 1'b1;
          if ((command_i == CMD_MUL) || (command_i == CMD_SQR)) begin
            state_d = S_MSEL;
          end else if (command_i == CMD_INV) begin
            state_d = S_INV;
          end else begin
            state_d = S_ARITH;
          end
        end
      end
      S_ARITH: begin
        if (cmd_q == CMD_ADD) begin
          ctl_o.op = OP_ADD;
          state_d  = S_FIXC;
        end else if (cmd_q == CMD_SUB) begin
          ctl_o.op = OP_SUB;
          state_d  = S_FIXP;
        end else begin
          ctl_o.op = OP_ZERO;
          state_d  = S_OUT;
        end
      end
      S_FIXC: begin
        ctl_o.op = OP_FIXC;
        state_d  = S_CSUB;
      end
      S_FIXP: begin
        ctl_o.op = OP_FIXP;
        state_d  = S_OUT;
      end
      S_CSUB: begin
        ctl_o.op = OP_CSUB;
        state_d  = (cmd_q == CMD_INV) ? S_STORE : S_OUT;
      end
      // Exponent scan, least significant bit first.
      S_INV: begin
        if (n_q[8]) begin
          ctl_o.op = OP_INV_RES;
          state_d  = S_OUT;
        end else if (phase_q && !INV_EXP[n_q[7:0]]) begin
          phase_d = 1'b0;
        end else begin
          state_d = S_MSEL;
        end
      end
      S_MSEL: begin
        ctl_o.op = OP_MSEL;
        if (cmd_q == CMD_MUL) begin
          ctl_o.msel = MSEL_A_B;
        end else if (cmd_q == CMD_SQR) begin
          ctl_o.msel = MSEL_A_A;
        end else begin
          ctl_o.msel = phase_q ? MSEL_ACC_BASE : MSEL_BASE_BASE;
        end
        k_d     = 4'd0;
        i_d     = 3'd0;
        state_d = S_PROD;
      end
      // One limb product per cycle, column by column.
      S_PROD: begin
        ctl_o.op       = OP_PROD;
        ctl_o.col_last = (i_q == i_hi);
        if (i_q == i_hi) begin
          if (k_q == 4'd14) begin
            state_d = S_PWAIT;
          end else begin
            k_d = k1;
            i_d = (k1 > 4'd7) ? 3'(k1 - 4'd7) : 3'd0;
          end
        end else begin
          i_d = i_q + 3'd1;
        end
      end
      S_PWAIT: begin
        state_d = S_FLUSH;
      end
      S_FLUSH: begin
        ctl_o.op = OP_FLUSH;
        step_d   = 4'd0;
        state_d  = S_FOLD;
      end
      S_FOLD: begin
        ctl_o.op       = OP_FOLD;
        ctl_o.fold_low = (step_q != 4'd8);
        ctl_o.fold_sh  = (step_q != 4'd0);
        if (step_q == 4'd8) begin
          state_d = S_FWAIT;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      S_FWAIT: begin
        state_d = S_F2MUL;
      end
      S_F2MUL: begin
        ctl_o.op = OP_F2MUL;
        state_d  = S_F2ADD;
      end
      S_F2ADD: begin
        ctl_o.op = OP_F2ADD;
        state_d  = S_FIXC;
      end
      S_STORE: begin
        if (phase_q) begin
          ctl_o.op = OP_ST_ACC;
          phase_d  = 1'b0;
        end else begin
          ctl_o.op = OP_ST_BASE;
          phase_d  = 1'b1;
          n_d      = n_q + 9'd1;
        end
        state_d = S_INV;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          ctl_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= 3'd0;
      k_q         <= 4'd0;
      i_q         <= 3'd0;
      step_q      <= 4'd0;
      n_q         <= 9'd0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      k_q         <= k_d;
      i_q         <= i_d;
      step_q      <= step_d;
      n_q         <= n_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/sfa_checker.sv -----
module sfa_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [63:0] result_limb_0_o,
  input  logic [63:0] result_limb_1_o,
  input  logic [63:0] result_limb_2_o,
  input  logic [63:0] result_limb_3_o
);

  // Command codes that the block leaves unused.
  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // An accepted beat keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_limb_0_o)
      && $stable(result_limb_1_o) && $stable(result_limb_2_o)
      && $stable(result_limb_3_o)))
    else $error("stalled result changed");

  // A new result only follows an item in flight.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without item");

  // Unused command codes give a zero result when no earlier result is pending at accept.
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_valid_o &&
     (command_i == CMD_SPARE_5 || command_i == CMD_SPARE_6 || command_i == CMD_SPARE_7))
    |-> ##3 (out_valid_o && result_limb_0_o == 64'd0 && result_limb_1_o == 64'd0
      && result_limb_2_o == 64'd0 && result_limb_3_o == 64'd0))
    else $error("unused command result not zero");

endmodule

bind secp256k1_field_alu_top sfa_checker u_sfa_checker (.*);
